FILE: rtl/assert_macros.svh
// assertion helpers for the rtl file that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define URTM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("urtm assertion failed");

// condition that must never be true outside reset
`define URTM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("urtm forbidden condition seen");

`endif

FILE: rtl/urtm_pkg.sv
`default_nettype none

package urtm_pkg;

  // field widths
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned EDGE_W  = 2;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned OFFS_W  = 10;
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = 11;
  localparam int unsigned CFG_W   = 16;

  // largest window entry: any error code over 58
  localparam int unsigned ENTRY_MAX = 1129;
  localparam logic [ENTRY_W-1:0] ERR_ENTRY = ENTRY_W'(ENTRY_MAX);

  // divide by 58 for a 15-bit half count: (x * 36158) >> 21 is exact
  localparam int unsigned HALF_W    = COUNT_W - 1;
  localparam int unsigned CM_SHIFT  = 21;
  localparam int unsigned CM_PROD_W = CM_SHIFT + ENTRY_W;
  localparam logic [COUNT_W-1:0] CM_RECIP = 16'd36158;

  // edge status codes
  localparam logic [EDGE_W-1:0] EDGE_FALL_TMO = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] RES_VALID    = 2'd0;
  localparam logic [STAT_W-1:0] RES_RISE_ERR = 2'd1;
  localparam logic [STAT_W-1:0] RES_FALL_ERR = 2'd2;
  localparam logic [STAT_W-1:0] RES_NO_OBST  = 2'd3;

  // configuration register indexes
  localparam logic REG_NO_OBST_LIMIT = 1'b0;
  localparam logic REG_REV_OFFSET    = 1'b1;

  typedef struct packed {
    logic load;
    logic push;
    logic walk;
    logic trim;
    logic mul;
    logic finish;
  } urtm_cmd_t;

  typedef struct packed {
    logic walk_last;
  } urtm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/urtm_ctrl.sv
`default_nettype none

module urtm_ctrl
  import urtm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  input  urtm_stat_t stat_i,
  output urtm_cmd_t  cmd_o,
  output logic       in_stall_o,
  output logic       out_valid_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_TRIM = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  urtm_cmd_t  cmd;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_q == S_IDLE) && in_valid_i;
    cmd.push   = (state_q == S_PUSH);
    cmd.walk   = (state_q == S_WALK);
    cmd.trim   = (state_q == S_TRIM);
    cmd.mul    = (state_q == S_MUL);
    // output register free or being drained this cycle
    cmd.finish = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd.load) state_d = S_PUSH;
      end
      S_PUSH: state_d = S_WALK;
      S_WALK: begin
        if (stat_i.walk_last) state_d = S_TRIM;
      end
      S_TRIM: state_d = S_MUL;
      S_MUL:  state_d = S_DONE;
      S_DONE: begin
        if (cmd.finish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/urtm_dp.sv
`default_nettype none

module urtm_dp
  import urtm_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  urtm_cmd_t                cmd_i,
  output urtm_stat_t               stat_o,
  input  logic [COUNT_W-1:0]       pulse_count_i,
  input  logic [EDGE_W-1:0]        edge_status_i,
  input  logic [LIMIT_W-1:0]       no_obst_limit_i,
  input  logic [OFFS_W-1:0]        rev_offset_i,
  output logic signed [DIST_W-1:0] distance_value_o,
  output logic [STAT_W-1:0]        result_status_o
);

  localparam int unsigned IDX_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W    = $clog2(ENTRY_MAX * WINDOW_LEN + 1);
  // trimmed mean by reciprocal: exact for any value below 2**SUM_W
  localparam int unsigned TRIM_DIV = WINDOW_LEN - 2;
  localparam int unsigned TRIM_L   = (TRIM_DIV > 1) ? $clog2(TRIM_DIV) : 0;
  localparam int unsigned TRIM_SH  = SUM_W + TRIM_L;
  localparam int unsigned MUL_W    = SUM_W + 2;
  localparam int unsigned PROD_W   = SUM_W + MUL_W;
  localparam longint unsigned TRIM_M =
    ((64'd1 << TRIM_SH) + TRIM_DIV - 1) / TRIM_DIV;
  localparam logic [MUL_W-1:0] TRIM_M_V = MUL_W'(TRIM_M);

  logic [ENTRY_W-1:0]   window_q [WINDOW_LEN];
  logic [STAT_W-1:0]    status_q, status_d;
  logic [CM_PROD_W-1:0] cm_prod_q;
  logic [HALF_W-1:0]    half;
  logic [ENTRY_W-1:0]   new_entry;
  logic [IDX_W-1:0]     idx_q;
  logic [SUM_W-1:0]     sum_q;
  logic [ENTRY_W-1:0]   hi_q, lo_q, cur;
  logic [SUM_W-1:0]     trim_q;
  logic [PROD_W-1:0]    prod_q;
  logic [ENTRY_W-1:0]   avg;
  logic [DIST_W-1:0]    dist_val;

  // classify the beat; bit 0 of the edge status flags a rise timeout
  always_comb begin
    if (edge_status_i[0]) begin
      status_d = RES_RISE_ERR;
    end else if (edge_status_i == EDGE_FALL_TMO) begin
      status_d = RES_FALL_ERR;
    end else if (pulse_count_i > no_obst_limit_i) begin
      status_d = RES_NO_OBST;
    end else begin
      status_d = RES_VALID;
    end
  end

  assign half      = pulse_count_i[COUNT_W-1:1];
  assign new_entry = (status_q != RES_VALID) ? ERR_ENTRY : cm_prod_q[CM_SHIFT +: ENTRY_W];
  assign cur       = window_q[idx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q  <= status_d;
      cm_prod_q <= CM_PROD_W'(half) * CM_PROD_W'(CM_RECIP);
    end
  end

  // window: entry 0 is the newest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) window_q[i] <= '0;
    end else if (cmd_i.push) begin
      window_q[0] <= new_entry;
      for (int i = 1; i < WINDOW_LEN; i++) window_q[i] <= window_q[i-1];
    end
  end

  // walk: one entry per cycle into sum, max and min
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      idx_q <= '0;
      sum_q <= '0;
      hi_q  <= '0;
      lo_q  <= '1;
    end else if (cmd_i.walk) begin
      idx_q <= idx_q + IDX_W'(1);
      sum_q <= sum_q + SUM_W'(cur);
      if (cur > hi_q) hi_q <= cur;
      if (cur < lo_q) lo_q <= cur;
    end
  end

  assign stat_o.walk_last = (idx_q == IDX_W'(WINDOW_LEN - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.trim) trim_q <= sum_q - SUM_W'(hi_q) - SUM_W'(lo_q);
    if (cmd_i.mul)  prod_q <= PROD_W'(trim_q) * PROD_W'(TRIM_M_V);
  end

  assign avg      = prod_q[TRIM_SH +: ENTRY_W];
  assign dist_val = (status_q == RES_VALID)
                  ? (DIST_W'(rev_offset_i) - DIST_W'(avg)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      distance_value_o <= $signed(dist_val);
      result_status_o  <= status_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_range_trimmed_mean_top.sv
// Ultrasonic range back end. Each input beat is one echo measurement (timer
// count and edge status); each one yields exactly one result beat with the
// offset-minus-trimmed-mean distance and a status (0 valid, 1 rise timeout,
// 2 fall timeout, 3 no obstacle; distance is zero unless status is 0). An
// edge status of 3 counts as a rise timeout. The half count over 58 (1129 for any
// error) enters a WINDOW_LEN deep window that reset clears; the mean drops one
// maximum and one minimum entry. One beat is handled at a time: each beat is
// pushed, then the window is walked one entry per cycle, then trimmed and
// multiplied; the result is then registered into the output register, which
// may wait on out_stall_i, and only then is the next beat taken. A finished
// result waits in the output register while the next beat is taken.
// Configuration: index 0 no_obstacle_limit (reset 60000), index 1
// reverse_offset (reset 300); write only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module ultrasonic_range_trimmed_mean_top
  import urtm_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // measurement beats
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [COUNT_W-1:0]       pulse_count_i,
  input  logic [EDGE_W-1:0]        edge_status_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DIST_W-1:0] distance_value_o,
  output logic [STAT_W-1:0]        result_status_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  urtm_cmd_t          cmd;
  urtm_stat_t         stat;
  logic [LIMIT_W-1:0] no_obst_limit_q;
  logic [OFFS_W-1:0]  rev_offset_q;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_obst_limit_q <= 16'd60000;
      rev_offset_q    <= 10'd300;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NO_OBST_LIMIT: no_obst_limit_q <= cfg_data_i;
        REG_REV_OFFSET:    rev_offset_q    <= cfg_data_i[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: accept, push, walk, trim, multiply, deliver
  urtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // window, running max/min/sum and the two reciprocal multipliers
  urtm_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .pulse_count_i    (pulse_count_i),
    .edge_status_i    (edge_status_i),
    .no_obst_limit_i  (no_obst_limit_q),
    .rev_offset_i     (rev_offset_q),
    .distance_value_o (distance_value_o),
    .result_status_o  (result_status_o)
  );

  // an accepted beat keeps the block busy for the next cycle
  `URTM_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a result only appears out of a busy cycle
  `URTM_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))
  // error results carry a zero distance
  `URTM_NEVER(a_err_dist_zero, clk_i, rst_ni, out_valid_o && (result_status_o != RES_VALID) && (distance_value_o != '0))

endmodule

`default_nettype wire
